>>> src/vtp_pkg.sv
// shared types and constants for the perspective vertex transform
// no dependencies; used by every file in src
package vtp_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int NUM_REGS      = 8;
  localparam int CFG_IDX_W     = 4;
  localparam int COMP_W        = 32;

  // action codes
  localparam logic ACT_FULL  = 1'b0;
  localparam logic ACT_POINT = 1'b1;

  typedef struct packed {
    logic               action;
    logic signed [31:0] vec_x;
    logic signed [31:0] vec_y;
    logic signed [31:0] vec_z;
    logic signed [31:0] vec_w;
  } in_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic signed [31:0] out_w;
    logic               divide_by_zero;
    logic               saturated;
  } out_t;

  // side data that rides along the divide pipeline
  typedef struct packed {
    logic               action;
    logic               dz;
    logic               sat;
    logic [2:0]         neg;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic signed [31:0] w;
  } meta_t;

endpackage

>>> src/vtp_divider.sv
// pipelined restoring divider, three lanes sharing one divisor, one quotient bit per stage
// depends on vtp_pkg (meta_t)
module vtp_divider #(
  parameter int FRAC_BITS = vtp_pkg::FRAC_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            en,
  input  logic                            in_vld,
  input  logic [2:0][31:0]                in_mag,
  input  logic [31:0]                     in_den,
  input  vtp_pkg::meta_t                  in_meta,
  output logic                            q_vld,
  output logic [2:0][FRAC_BITS+31:0]      q_mag,
  output vtp_pkg::meta_t                  q_meta
);

  localparam int NW = 32 + FRAC_BITS;

  logic [NW:0]                  vld;
  logic [2:0][31:0]             rem  [NW+1];
  logic [2:0][NW-1:0]           nq   [NW+1];
  logic [31:0]                  den  [NW+1];
  vtp_pkg::meta_t               meta [NW+1];

  // valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NW-1:0], in_vld};
    end
  end

  // stage zero: numerator is magnitude shifted up by the fraction bits
  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < 3; l++) begin
        rem[0][l] <= '0;
        nq[0][l]  <= {in_mag[l], {FRAC_BITS{1'b0}}};
      end
      den[0]  <= in_den;
      meta[0] <= in_meta;
    end
  end

  // one quotient bit per stage
  for (genvar k = 0; k < NW; k++) begin : g_stage
    logic [2:0][32:0] sh;
    logic [2:0][33:0] diff;
    always_comb begin
      for (int l = 0; l < 3; l++) begin
        sh[l]   = {rem[k][l], nq[k][l][NW-1]};
        diff[l] = {1'b0, sh[l]} - {2'b00, den[k]};
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        for (int l = 0; l < 3; l++) begin
          rem[k+1][l] <= diff[l][33] ? sh[l][31:0] : diff[l][31:0];
          nq[k+1][l]  <= {nq[k][l][NW-2:0], ~diff[l][33]};
        end
        den[k+1]  <= den[k];
        meta[k+1] <= meta[k];
      end
    end
  end

  assign q_vld  = vld[NW];
  assign q_mag  = nq[NW];
  assign q_meta = meta[NW];

endmodule

>>> src/vertex_transform_perspective.sv
// top level: 4x4 fixed-point vertex transform with optional perspective divide
// depends on vtp_pkg and vtp_divider
//
//   channel | dir | handshake             | payload
//   --------+-----+-----------------------+------------------------
//   in      | in  | in_valid / in_stall   | in_data (vtp_pkg::in_t)
//   out     | out | out_valid / out_stall | out_data (vtp_pkg::out_t)
//   cfg     | in  | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// one vertex enters per cycle while no stalled output beat holds it; the divider
//   retires one quotient bit per stage
// rst is synchronous and restores the identity matrix and empties the pipeline
// a stalled output beat freezes every stage; in_stall follows it, so nothing is lost
// cfg_ready is always high
module vertex_transform_perspective #(
  parameter int FRAC_BITS = vtp_pkg::FRAC_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  vtp_pkg::in_t                   in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output vtp_pkg::out_t                  out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [vtp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [63:0]                    cfg_data
);

  localparam int NW = 32 + FRAC_BITS;
  localparam logic [63:0] ONE_LO = 64'(1) << FRAC_BITS;
  localparam logic [63:0] ONE_HI = ONE_LO << 32;
  localparam logic [NW-1:0] LIM_POS = NW'(32'h7fff_ffff);
  localparam logic [NW-1:0] LIM_NEG = NW'(32'h8000_0000);

  logic adv;
  logic [63:0] coef [vtp_pkg::NUM_REGS];

  assign adv       = !(out_valid && out_stall);
  assign in_stall  = !adv;
  assign cfg_ready = 1'b1;

  // matrix registers, identity at reset
  always_ff @(posedge clk) begin
    if (rst) begin
      coef[0] <= ONE_LO; coef[1] <= '0; coef[2] <= ONE_HI; coef[3] <= '0;
      coef[4] <= '0;     coef[5] <= ONE_LO; coef[6] <= '0; coef[7] <= ONE_HI;
    end else if (cfg_valid && cfg_index < vtp_pkg::CFG_IDX_W'(vtp_pkg::NUM_REGS)) begin
      coef[cfg_index[2:0]] <= cfg_data;
    end
  end

  // stage 0: input register, w forced to one for point transforms
  logic                     s0_vld, s0_act;
  logic signed [3:0][31:0]  s0_v;
  always_ff @(posedge clk) begin
    if (rst) s0_vld <= 1'b0;
    else if (adv) s0_vld <= in_valid;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      s0_act  <= in_data.action;
      s0_v[0] <= in_data.vec_x;
      s0_v[1] <= in_data.vec_y;
      s0_v[2] <= in_data.vec_z;
      s0_v[3] <= (in_data.action == vtp_pkg::ACT_POINT) ? ONE_LO[31:0] : in_data.vec_w;
    end
  end

  // stage 1: sixteen products
  logic                s1_vld, s1_act;
  logic signed [63:0]  s1_p [4][4];
  always_ff @(posedge clk) begin
    if (rst) s1_vld <= 1'b0;
    else if (adv) s1_vld <= s0_vld;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_act <= s0_act;
      for (int r = 0; r < 4; r++)
        for (int c = 0; c < 4; c++)
          s1_p[r][c] <= $signed(coef[r*2 + c/2][(c%2)*32 +: 32]) * $signed(s0_v[c]);
    end
  end

  // stage 2: pair sums
  logic                s2_vld, s2_act;
  logic signed [64:0]  s2_s [4][2];
  always_ff @(posedge clk) begin
    if (rst) s2_vld <= 1'b0;
    else if (adv) s2_vld <= s1_vld;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      s2_act <= s1_act;
      for (int r = 0; r < 4; r++)
        for (int h = 0; h < 2; h++)
          s2_s[r][h] <= {s1_p[r][2*h][63], s1_p[r][2*h]}
                      + {s1_p[r][2*h+1][63], s1_p[r][2*h+1]};
    end
  end

  // stage 3: exact row sums
  logic                s3_vld, s3_act;
  logic signed [65:0]  s3_sum [4];
  always_ff @(posedge clk) begin
    if (rst) s3_vld <= 1'b0;
    else if (adv) s3_vld <= s2_vld;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      s3_act <= s2_act;
      for (int r = 0; r < 4; r++)
        s3_sum[r] <= {s2_s[r][0][64], s2_s[r][0]} + {s2_s[r][1][64], s2_s[r][1]};
    end
  end

  // stage 4: floor shift and clamp to 32 bits
  logic signed [65:0]       shr  [4];
  logic [3:0]               fits;
  logic                     s4_vld, s4_act;
  logic signed [3:0][31:0]  s4_r;
  logic [3:0]               s4_sat;
  always_comb begin
    for (int r = 0; r < 4; r++) begin
      shr[r]  = s3_sum[r] >>> FRAC_BITS;
      fits[r] = (shr[r][65:31] == '0) || (shr[r][65:31] == '1);
    end
  end
  always_ff @(posedge clk) begin
    if (rst) s4_vld <= 1'b0;
    else if (adv) s4_vld <= s3_vld;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      s4_act <= s3_act;
      for (int r = 0; r < 4; r++) begin
        s4_sat[r] <= !fits[r];
        if (fits[r])        s4_r[r] <= shr[r][31:0];
        else if (shr[r][65]) s4_r[r] <= 32'sh8000_0000;
        else                s4_r[r] <= 32'sh7fff_ffff;
      end
    end
  end

  // divide setup: magnitudes, signs, zero w
  logic [2:0][31:0] mag;
  logic [31:0]      den;
  vtp_pkg::meta_t   meta_in;
  always_comb begin
    for (int l = 0; l < 3; l++)
      mag[l] = s4_r[l][31] ? (~s4_r[l] + 32'd1) : s4_r[l];
    den = s4_r[3][31] ? (~s4_r[3] + 32'd1) : s4_r[3];
    meta_in.action = s4_act;
    meta_in.dz     = (s4_act == vtp_pkg::ACT_POINT) && (s4_r[3] == '0);
    meta_in.sat    = meta_in.dz ? s4_sat[3] : (|s4_sat);
    for (int l = 0; l < 3; l++)
      meta_in.neg[l] = s4_r[l][31] ^ s4_r[3][31];
    meta_in.x = s4_r[0];
    meta_in.y = s4_r[1];
    meta_in.z = s4_r[2];
    meta_in.w = s4_r[3];
  end

  logic                        q_vld;
  logic [2:0][NW-1:0]          q_mag;
  vtp_pkg::meta_t              q_meta;

  vtp_divider #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk     (clk),
    .rst     (rst),
    .en      (adv),
    .in_vld  (s4_vld),
    .in_mag  (mag),
    .in_den  (den),
    .in_meta (meta_in),
    .q_vld   (q_vld),
    .q_mag   (q_mag),
    .q_meta  (q_meta)
  );

  // quotient sign and clamp, then select per action
  logic [2:0][31:0] qv;
  logic [2:0]       qsat;
  vtp_pkg::out_t    res;
  always_comb begin
    for (int l = 0; l < 3; l++) begin
      if (q_meta.neg[l]) begin
        qsat[l] = q_mag[l] > LIM_NEG;
        qv[l]   = qsat[l] ? 32'h8000_0000 : (~q_mag[l][31:0] + 32'd1);
      end else begin
        qsat[l] = q_mag[l] > LIM_POS;
        qv[l]   = qsat[l] ? 32'h7fff_ffff : q_mag[l][31:0];
      end
    end
    res.out_w          = q_meta.w;
    res.divide_by_zero = q_meta.dz;
    if (q_meta.action == vtp_pkg::ACT_FULL) begin
      res.out_x     = q_meta.x;
      res.out_y     = q_meta.y;
      res.out_z     = q_meta.z;
      res.saturated = q_meta.sat;
    end else if (q_meta.dz) begin
      res.out_x     = '0;
      res.out_y     = '0;
      res.out_z     = '0;
      res.saturated = q_meta.sat;
    end else begin
      res.out_x     = qv[0];
      res.out_y     = qv[1];
      res.out_z     = qv[2];
      res.saturated = q_meta.sat | (|qsat);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (adv) out_valid <= q_vld;
  end
  always_ff @(posedge clk) begin
    if (adv) out_data <= res;
  end

endmodule

>>> src/vtp_checker.sv
// port-level checks for the vertex transform, bound to the top level
// depends on vtp_pkg and vertex_transform_perspective
module vtp_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           in_stall,
  input logic                           out_valid,
  input logic                           out_stall,
  input vtp_pkg::out_t                  out_data
);

  // a stalled result beat holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled output beat changed");

  // input only stalls behind a stalled output beat
  a_stall: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output back-pressure");

  // a zero divisor gives zero components and a clear saturated flag
  a_dz: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.divide_by_zero |->
      out_data.out_x == '0 && out_data.out_y == '0 &&
      out_data.out_z == '0 && out_data.out_w == '0 && !out_data.saturated)
    else $error("divide by zero beat not cleared");

  // reset empties the pipeline
  a_rst: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind vertex_transform_perspective vtp_checker u_vtp_checker (
  .clk       (clk),
  .rst       (rst),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

>>> tb/sv/testbench.sv
// self-checking testbench for vertex_transform_perspective
// depends on vtp_pkg and the block under src; drives random and directed vertices
`timescale 1ns / 1ps

module testbench;

  localparam int FB        = vtp_pkg::FRAC_BITS_DEF;
  localparam int LATENCY   = FB + 39;
  localparam int N_RANDOM  = 600;
  localparam int CYC_LIMIT = 400000;
  localparam int REG_IDX_W = $clog2(vtp_pkg::NUM_REGS);

  // register index
  localparam logic [vtp_pkg::CFG_IDX_W-1:0] R_32_33 = 4'd7;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  vtp_pkg::in_t  in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  vtp_pkg::out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [vtp_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [63:0] cfg_data = '0;

  vertex_transform_perspective u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  // matrix copy and pending vertex results
  logic [63:0]   matrix_regs [vtp_pkg::NUM_REGS];
  vtp_pkg::out_t vertex_q [$];
  int            mismatches = 0;
  int            cycles = 0;
  bit            idle_en = 1'b0;
  int            hold_off = 0;

  function automatic longint coef_of(int row, int col);
    logic [63:0] r;
    logic signed [31:0] c;
    r = matrix_regs[row * 2 + col / 2];
    c = (col % 2) ? r[63:32] : r[31:0];
    return longint'(c);
  endfunction

  function automatic longint clamp_word(longint v, ref bit sat);
    if (v > 64'sd2147483647) begin
      sat = 1'b1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      sat = 1'b1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  // exact row sum, floor shift, then clamp
  function automatic longint row_dot(int row, longint v [4], ref bit sat);
    logic signed [127:0] acc;
    acc = '0;
    for (int k = 0; k < 4; k++)
      acc += 128'(coef_of(row, k)) * 128'(v[k]);
    acc = acc >>> FB;
    if (acc > 128'sd2147483647) begin
      sat = 1'b1;
      return 64'sd2147483647;
    end
    if (acc < -128'sd2147483648) begin
      sat = 1'b1;
      return -64'sd2147483648;
    end
    return longint'(acc);
  endfunction

  function automatic vtp_pkg::out_t transform_vertex(vtp_pkg::in_t d);
    longint v [4];
    longint r [4];
    bit sat, satw;
    vtp_pkg::out_t o;
    sat = 1'b0;
    satw = 1'b0;
    o = '0;
    v[0] = longint'(d.vec_x);
    v[1] = longint'(d.vec_y);
    v[2] = longint'(d.vec_z);
    v[3] = (d.action == vtp_pkg::ACT_POINT) ? (64'sd1 <<< FB) : longint'(d.vec_w);
    if (d.action == vtp_pkg::ACT_FULL) begin
      for (int i = 0; i < 4; i++) r[i] = row_dot(i, v, sat);
    end else begin
      r[3] = row_dot(3, v, satw);
      for (int i = 0; i < 3; i++) r[i] = row_dot(i, v, sat);
      if (r[3] == 0) begin
        o.divide_by_zero = 1'b1;
        r[0] = 0; r[1] = 0; r[2] = 0;
        sat = satw;
      end else begin
        // truncating divide of x * 2^FB by w
        for (int i = 0; i < 3; i++) r[i] = clamp_word((r[i] <<< FB) / r[3], sat);
        sat = sat | satw;
      end
    end
    o.out_x = r[0][31:0];
    o.out_y = r[1][31:0];
    o.out_z = r[2][31:0];
    o.out_w = r[3][31:0];
    o.saturated = sat;
    return o;
  endfunction

  // one config beat, then the channel is left idle before the task returns
  task automatic write_coef(logic [vtp_pkg::CFG_IDX_W-1:0] idx, logic [63:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    matrix_regs[idx[REG_IDX_W-1:0]] = val;
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // valid stays high after a beat so that the next one can follow at once
  task automatic send_vertex(vtp_pkg::in_t d, bit check_typed, vtp_pkg::out_t typed);
    vtp_pkg::out_t e;
    if (idle_en && $urandom_range(99) < 29) begin
      in_valid <= 1'b0;
      do @(negedge clk); while (idle_en && $urandom_range(99) < 29);
    end
    in_valid <= 1'b1;
    in_data  <= d;
    do @(posedge clk); while (in_stall);
    e = transform_vertex(d);
    if (check_typed && e !== typed) begin
      mismatches++;
      if (mismatches <= 10)
        $display("predictor disagrees with table: exp %h got %h", typed, e);
    end
    vertex_q.push_back(e);
    @(negedge clk);
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (vertex_q.size() != 0) @(negedge clk);
    repeat (LATENCY + 10) @(negedge clk);
  endtask

  function automatic logic [31:0] rnd_word();
    case ($urandom_range(5))
      0: return 32'h8000_0000 | $urandom_range(3);
      1: return 32'h7fff_fffc | $urandom_range(3);
      2: return $urandom_range(0, 32'h3_ffff) - 32'h1_ffff;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [63:0] rnd_reg();
    return {rnd_word(), rnd_word()};
  endfunction

  // result checking at the rising edge
  always @(posedge clk) begin
    vtp_pkg::out_t e;
    cycles <= cycles + 1;
    if (!rst && out_valid && !out_stall) begin
      if (vertex_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected beat %h", out_data);
      end else begin
        e = vertex_q.pop_front();
        if (out_data.out_x !== e.out_x || out_data.out_y !== e.out_y ||
            out_data.out_z !== e.out_z || out_data.out_w !== e.out_w ||
            out_data.divide_by_zero !== e.divide_by_zero ||
            out_data.saturated !== e.saturated) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch exp %h got %h", e, out_data);
        end
      end
    end
  end

  // receiver stall, with one long hold-off
  always @(negedge clk) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= idle_en && ($urandom_range(99) < 29);
    end
  end

  always @(posedge clk) begin
    if (cycles > CYC_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  typedef struct {
    vtp_pkg::in_t  vin;
    bit            typed;
    vtp_pkg::out_t res;
  } stim_row_t;

  stim_row_t rows [$];

  initial begin
    vtp_pkg::in_t d;
    matrix_regs = '{64'h1_0000, 64'h0, 64'h1_0000 << 32, 64'h0,
                    64'h0, 64'h1_0000, 64'h0, 64'h1_0000 << 32};
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed table under the reset identity matrix
    rows.push_back('{'{vtp_pkg::ACT_FULL, 32'sd1, 32'sd2, 32'sd3, 32'sd4}, 1'b1,
                     '{32'sd1, 32'sd2, 32'sd3, 32'sd4, 1'b0, 1'b0}});
    rows.push_back('{'{vtp_pkg::ACT_FULL, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
                     32'h7fff_ffff}, 1'b1,
                     '{32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
                       1'b0, 1'b0}});
    rows.push_back('{'{vtp_pkg::ACT_POINT, 32'sd65536, -32'sd65536, 32'sd0, 32'sd0}, 1'b1,
                     '{32'sd65536, -32'sd65536, 32'sd0, 32'sd65536, 1'b0, 1'b0}});
    rows.push_back('{'{vtp_pkg::ACT_POINT, 32'h7fff_ffff, 32'h8000_0000, 32'sd5,
                       32'hffff_ffff}, 1'b0, '0});
    rows.push_back('{'{vtp_pkg::ACT_FULL, -32'sd1, -32'sd1, -32'sd1, -32'sd1}, 1'b0, '0});
    foreach (rows[i]) send_vertex(rows[i].vin, rows[i].typed, rows[i].res);
    drain();

    // zero w row: point transform divides by zero
    write_coef(R_32_33, 64'h0);
    send_vertex('{vtp_pkg::ACT_POINT, 32'sd7, 32'sd8, 32'sd9, 32'sd1}, 1'b1,
                '{32'sd0, 32'sd0, 32'sd0, 32'sd0, 1'b1, 1'b0});
    drain();
    // large gain forces clamping in both actions
    for (int i = 0; i < vtp_pkg::NUM_REGS; i++)
      write_coef(i[vtp_pkg::CFG_IDX_W-1:0], 64'h7fff_ffff_7fff_ffff);
    send_vertex('{vtp_pkg::ACT_FULL, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                  32'h7fff_ffff}, 1'b1,
                '{32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                  1'b0, 1'b1});
    send_vertex('{vtp_pkg::ACT_POINT, 32'h8000_0000, 32'sd3, 32'h8000_0000, 32'sd0},
                1'b0, '0);
    drain();
    write_coef(R_32_33, 64'h8000_0000_8000_0000);
    send_vertex('{vtp_pkg::ACT_POINT, 32'sd1, 32'sd1, 32'sd1, 32'sd0}, 1'b0, '0);
    send_vertex('{vtp_pkg::ACT_POINT, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                  32'sd0}, 1'b0, '0);
    drain();

    // random phases with fresh matrices, pressure in the middle
    idle_en = 1'b1;
    for (int ph = 0; ph < 6; ph++) begin
      for (int i = 0; i < vtp_pkg::NUM_REGS; i++)
        write_coef(i[vtp_pkg::CFG_IDX_W-1:0], (ph == 5) ? 64'h0 : rnd_reg());
      if (ph == 2) begin
        hold_off = 150;
        idle_en = 1'b0;
      end
      for (int n = 0; n < N_RANDOM / 6; n++) begin
        d.action = 1'($urandom_range(1));
        d.vec_x = rnd_word();
        d.vec_y = rnd_word();
        d.vec_z = rnd_word();
        d.vec_w = rnd_word();
        send_vertex(d, 1'b0, '0);
      end
      idle_en = 1'b1;
      drain();
    end

    if (mismatches == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule
